// File: src/gsr_pkg.sv
// gsr_pkg: shared constants and types for the GJK simplex refine block.
// Holds status codes, sequencer states and operand select codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsr_pkg;

  // default coordinate width (signed Q8.8)
  localparam int GSR_COORD_BITS = 16;
  // width of each direction field on the result channel
  localparam int DIR_OUT_BITS   = 54;

  // product counts of the two shared-unit operations
  localparam logic [3:0] NP_CROSS = 4'd12;
  localparam logic [3:0] NP_DOT   = 4'd6;

  // result status codes
  localparam logic [1:0] ST_CONTINUE  = 2'd0;
  localparam logic [1:0] ST_COLLISION = 2'd1;
  localparam logic [1:0] ST_SEPARATED = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  // sequencer states: every state between IDLE and DONE runs one operation
  typedef enum logic [4:0] {
    S_IDLE,
    S_DOT_S,
    S_LN_DOT,
    S_LN_X1,
    S_LN_X2,
    S_TR_ABC,
    S_TR_X1,
    S_TR_D1,
    S_TR_D2,
    S_TR_X3,
    S_TR_X4,
    S_TR_X5,
    S_TR_D3,
    S_TR_D4,
    S_TE_X1,
    S_TE_D1,
    S_TE_X2,
    S_TE_D2,
    S_TE_X3,
    S_TE_D3,
    S_DONE
  } gsr_state_t;

  // wide operand select
  typedef enum logic [2:0] {
    U_DIR,
    U_ABC,
    U_T,
    U_AB,
    U_AC,
    U_AD
  } gsr_usel_t;

  // narrow operand select
  typedef enum logic [2:0] {
    V_S,
    V_AO,
    V_AB,
    V_AC,
    V_AD
  } gsr_vsel_t;

  // cross product destination
  typedef enum logic [1:0] {
    D_NONE,
    D_T,
    D_DIR,
    D_ABC
  } gsr_dst_t;

endpackage

`default_nettype wire

// File: src/gjk_simplex_refine.sv
// gjk_simplex_refine: simplex update of a 3-D GJK test, exact integer math.
// One shared multiply-accumulate unit runs every cross and dot product.
// Depends on gsr_pkg.
//
// channel | dir | tdata                         | tuser
// in_     | in  | support_x, support_y, support_z | start_req
// out_    | out | next_dir_x, next_dir_y, next_dir_z | status
//
// A start item or an ignored item goes straight to its result. Other items
// run a sequence of dot products and cross products on the one multiplier,
// one half-width partial product a cycle.
// Reset is synchronous; there is no clearing pass. in_tready is high only
// while the sequencer is idle; a finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module gjk_simplex_refine import gsr_pkg::*; #(
  parameter int COORD_BITS = GSR_COORD_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // support_x[15:0], support_y, support_z
  input  wire logic         in_tuser,   // start_req
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [167:0]      out_tdata,  // next_dir_x[53:0], next_dir_y, next_dir_z, zeros
  output logic [1:0]        out_tuser   // status
);

  localparam int CW  = COORD_BITS;
  localparam int NW  = CW + 1;            // differences
  localparam int DW  = 3 * CW + 5;        // widest direction
  localparam int H   = (DW + 1) / 2;      // low split of wide operand
  localparam int MAW = H + 1;
  localparam int PW  = MAW + NW;
  localparam int AW  = DW + CW + 3;
  localparam int RW  = (CW > 16) ? CW : 16;
  localparam int XW  = (DW > DIR_OUT_BITS) ? DW : DIR_OUT_BITS;

  gsr_state_t state_r, state_nxt;

  logic signed [CW-1:0] pts_r [4][3];
  logic signed [CW-1:0] s_r   [3];
  logic signed [CW-1:0] s_in  [3];
  logic signed [DW-1:0] dir_r [3];
  logic signed [DW-1:0] abc_r [3];
  logic signed [DW-1:0] t_r   [3];
  logic [2:0] cnt_r;
  logic       active_r;
  logic [1:0] st_r;

  logic [3:0] k_r;
  logic       p_vld_r, p_neg_r, p_hi_r, p_start_r, p_end_r;
  logic [1:0] p_comp_r;
  logic signed [PW-1:0] p_r;
  logic signed [AW-1:0] acc_r, acc_nxt;

  logic       out_vld_r;
  logic [1:0] out_status_r;
  logic [DIR_OUT_BITS-1:0] out_dir_r [3];

  // operation descriptor
  logic      op_cross, op_swap, in_op, op_done, dpos, fire, out_free;
  gsr_usel_t usel;
  gsr_vsel_t vsel;
  gsr_dst_t  dst;
  logic [3:0] np;
  logic [2:0] cnt_push;

  function automatic logic [1:0] inc3(input logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // input coordinates: low COORD_BITS bits of each field, zero-extended if wider than 16
  always_comb begin
    logic [RW-1:0] raw;
    for (int i = 0; i < 3; i++) begin
      raw     = RW'(in_tdata[16*i +: 16]);
      s_in[i] = raw[CW-1:0];
    end
  end

  // narrow difference vectors
  logic signed [NW-1:0] ao_v [3], ab_v [3], ac_v [3], ad_v [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ao_v[i] = -NW'(pts_r[0][i]);
      ab_v[i] = NW'(pts_r[1][i]) - NW'(pts_r[0][i]);
      ac_v[i] = NW'(pts_r[2][i]) - NW'(pts_r[0][i]);
      ad_v[i] = NW'(pts_r[3][i]) - NW'(pts_r[0][i]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          state_nxt = (in_tuser || !active_r) ? S_DONE : S_DOT_S;
        end
      end
      S_DOT_S: begin
        if (op_done) begin
          if (!dpos) state_nxt = S_DONE;
          else if (cnt_push == 3'd2) state_nxt = S_LN_DOT;
          else if (cnt_push == 3'd3) state_nxt = S_TR_ABC;
          else state_nxt = S_TE_X1;
        end
      end
      S_LN_DOT: if (op_done) state_nxt = dpos ? S_LN_X1 : S_DONE;
      S_LN_X1:  if (op_done) state_nxt = S_LN_X2;
      S_LN_X2:  if (op_done) state_nxt = S_DONE;
      S_TR_ABC: if (op_done) state_nxt = S_TR_X1;
      S_TR_X1:  if (op_done) state_nxt = S_TR_D1;
      S_TR_D1:  if (op_done) state_nxt = dpos ? S_TR_D2 : S_TR_X5;
      S_TR_D2:  if (op_done) state_nxt = dpos ? S_TR_X3 : S_LN_DOT;
      S_TR_X3:  if (op_done) state_nxt = S_TR_X4;
      S_TR_X4:  if (op_done) state_nxt = S_DONE;
      S_TR_X5:  if (op_done) state_nxt = S_TR_D3;
      S_TR_D3:  if (op_done) state_nxt = dpos ? S_LN_DOT : S_TR_D4;
      S_TR_D4:  if (op_done) state_nxt = S_DONE;
      S_TE_X1:  if (op_done) state_nxt = S_TE_D1;
      S_TE_D1:  if (op_done) state_nxt = dpos ? S_TR_ABC : S_TE_X2;
      S_TE_X2:  if (op_done) state_nxt = S_TE_D2;
      S_TE_D2:  if (op_done) state_nxt = dpos ? S_TR_ABC : S_TE_X3;
      S_TE_X3:  if (op_done) state_nxt = S_TE_D3;
      S_TE_D3:  if (op_done) state_nxt = dpos ? S_TR_ABC : S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // per-state outputs: handshake and operation descriptor
  always_comb begin
    in_tready = (state_r == S_IDLE);
    in_op     = 1'b1;
    op_cross  = 1'b0;
    op_swap   = 1'b0;
    usel      = U_DIR;
    vsel      = V_AO;
    dst       = D_NONE;
    unique case (state_r)
      S_IDLE, S_DONE: in_op = 1'b0;
      S_DOT_S:  vsel = V_S;
      S_LN_DOT: usel = U_AB;
      S_LN_X1:  begin op_cross = 1'b1; usel = U_AB;  dst = D_T;   end
      S_LN_X2:  begin op_cross = 1'b1; usel = U_T;   vsel = V_AB; dst = D_DIR; end
      S_TR_ABC: begin op_cross = 1'b1; usel = U_AB;  vsel = V_AC; dst = D_ABC; end
      S_TR_X1:  begin op_cross = 1'b1; usel = U_ABC; vsel = V_AC; dst = D_T;   end
      S_TR_D1, S_TR_D3, S_TE_D1, S_TE_D2, S_TE_D3: usel = U_T;
      S_TR_D2:  usel = U_AC;
      S_TR_X3:  begin op_cross = 1'b1; usel = U_AC;  dst = D_T;   end
      S_TR_X4:  begin op_cross = 1'b1; usel = U_T;   vsel = V_AC; dst = D_DIR; end
      S_TR_X5:  begin
        op_cross = 1'b1; op_swap = 1'b1; usel = U_ABC; vsel = V_AB; dst = D_T;
      end
      S_TR_D4:  usel = U_ABC;
      S_TE_X1:  begin op_cross = 1'b1; usel = U_AB;  vsel = V_AC; dst = D_T; end
      S_TE_X2:  begin op_cross = 1'b1; usel = U_AC;  vsel = V_AD; dst = D_T; end
      S_TE_X3:  begin op_cross = 1'b1; usel = U_AD;  vsel = V_AB; dst = D_T; end
      default:  in_op = 1'b0;
    endcase
  end

  assign fire     = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign np       = op_cross ? NP_CROSS : NP_DOT;
  assign op_done  = in_op && (k_r == np);
  assign cnt_push = ((cnt_r > 3'd3) ? 3'd3 : cnt_r) + 3'd1;

  // operand vectors
  logic signed [DW-1:0] u_vec [3];
  logic signed [NW-1:0] v_vec [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (usel)
        U_DIR:   u_vec[i] = dir_r[i];
        U_ABC:   u_vec[i] = abc_r[i];
        U_T:     u_vec[i] = t_r[i];
        U_AB:    u_vec[i] = DW'(ab_v[i]);
        U_AC:    u_vec[i] = DW'(ac_v[i]);
        default: u_vec[i] = DW'(ad_v[i]);
      endcase
      unique case (vsel)
        V_S:     v_vec[i] = NW'(s_r[i]);
        V_AO:    v_vec[i] = ao_v[i];
        V_AB:    v_vec[i] = ab_v[i];
        V_AC:    v_vec[i] = ac_v[i];
        default: v_vec[i] = ad_v[i];
      endcase
    end
  end

  // product issue: component, term and half from the step count
  logic [1:0] c_idx, ui, vi;
  logic       term, half, i_start, i_end;
  logic signed [DW-1:0]  u_sel;
  logic signed [MAW-1:0] mul_a;
  logic signed [PW-1:0]  prod;
  always_comb begin
    if (op_cross) begin
      c_idx   = k_r[3:2];
      term    = k_r[1];
      half    = k_r[0];
      i_start = (k_r[1:0] == 2'd0);
      i_end   = (k_r[1:0] == 2'd3);
      ui      = term ? inc3(inc3(c_idx)) : inc3(c_idx);
      vi      = term ? inc3(c_idx) : inc3(inc3(c_idx));
    end else begin
      c_idx   = k_r[2:1];
      term    = 1'b0;
      half    = k_r[0];
      i_start = (k_r == 4'd0);
      i_end   = (k_r == 4'd5);
      ui      = c_idx;
      vi      = c_idx;
    end
    u_sel = u_vec[ui];
    mul_a = half ? MAW'($signed(u_sel[DW-1:H])) : $signed({1'b0, u_sel[H-1:0]});
    prod  = mul_a * v_vec[vi];
  end

  // accumulate the registered product
  always_comb begin
    logic signed [AW-1:0] term_ext, sh, base;
    term_ext = AW'(p_r);
    sh       = p_hi_r ? (term_ext <<< H) : term_ext;
    base     = p_start_r ? '0 : acc_r;
    if (!p_vld_r) acc_nxt = acc_r;
    else if (p_neg_r) acc_nxt = base - sh;
    else acc_nxt = base + sh;
  end

  assign dpos = !acc_nxt[AW-1] && (acc_nxt != '0);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      p_vld_r   <= 1'b0;
      active_r  <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= in_op && !op_done;
      if (op_done || !in_op) k_r <= '0;
      else k_r <= k_r + 4'd1;

      if (fire && in_tuser) begin
        active_r <= 1'b1;
        cnt_r    <= 3'd1;
      end
      if (op_done) begin
        unique case (state_r)
          S_DOT_S: begin
            if (!dpos) active_r <= 1'b0;
            else cnt_r <= cnt_push;
          end
          S_LN_DOT: if (!dpos) cnt_r <= 3'd1;
          S_TR_D2:  cnt_r <= 3'd2;
          S_TR_D3:  if (dpos) cnt_r <= 3'd2;
          S_TE_D1, S_TE_D2: if (dpos) cnt_r <= 3'd3;
          S_TE_D3: begin
            if (dpos) cnt_r <= 3'd3;
            else active_r <= 1'b0;
          end
          default: ;
        endcase
      end

      if (state_r == S_DONE && out_free) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // product pipeline
    p_r       <= prod;
    p_neg_r   <= term ^ op_swap;
    p_hi_r    <= half;
    p_start_r <= i_start;
    p_end_r   <= i_end;
    p_comp_r  <= c_idx;
    acc_r     <= acc_nxt;

    // accepted request
    if (fire) begin
      s_r  <= s_in;
      st_r <= (in_tuser || active_r) ? ST_CONTINUE : ST_IGNORED;
      if (in_tuser) begin
        pts_r[0] <= s_in;
        for (int i = 0; i < 3; i++) dir_r[i] <= -DW'(s_in[i]);
      end
    end

    // cross product component write-back
    if (p_vld_r && p_end_r && op_cross) begin
      unique case (dst)
        D_T:     t_r[p_comp_r]   <= acc_nxt[DW-1:0];
        D_DIR:   dir_r[p_comp_r] <= acc_nxt[DW-1:0];
        D_ABC:   abc_r[p_comp_r] <= acc_nxt[DW-1:0];
        default: ;
      endcase
    end

    // simplex reduction steps at the end of the dot tests
    if (op_done) begin
      unique case (state_r)
        S_DOT_S: begin
          if (!dpos) st_r <= ST_SEPARATED;
          else begin
            pts_r[3] <= pts_r[2];
            pts_r[2] <= pts_r[1];
            pts_r[1] <= pts_r[0];
            pts_r[0] <= s_r;
          end
        end
        S_LN_DOT: begin
          if (!dpos) for (int i = 0; i < 3; i++) dir_r[i] <= DW'(ao_v[i]);
        end
        S_TR_D2: if (dpos) pts_r[1] <= pts_r[2];
        S_TR_D4: begin
          if (dpos) dir_r <= abc_r;
          else begin
            for (int i = 0; i < 3; i++) dir_r[i] <= -abc_r[i];
            pts_r[1] <= pts_r[2];
            pts_r[2] <= pts_r[1];
          end
        end
        S_TE_D2: begin
          if (dpos) begin
            pts_r[1] <= pts_r[2];
            pts_r[2] <= pts_r[3];
          end
        end
        S_TE_D3: begin
          if (dpos) begin
            pts_r[1] <= pts_r[3];
            pts_r[2] <= pts_r[1];
          end else st_r <= ST_COLLISION;
        end
        default: ;
      endcase
    end

    // result register
    if (state_r == S_DONE && out_free) begin
      out_status_r <= st_r;
      for (int i = 0; i < 3; i++) begin
        logic signed [XW-1:0] dext;
        dext = XW'(dir_r[i]);
        out_dir_r[i] <= (st_r == ST_IGNORED) ? '0 : dext[DIR_OUT_BITS-1:0];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_dir_r[2], out_dir_r[1], out_dir_r[0]};

endmodule

`default_nettype wire
